[rtl/fnv1a_bloom_filter_membership_top_defines.svh]
// Assertion macros shared by the FNV-1a Bloom filter RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef FNV1A_BLOOM_FILTER_MEMBERSHIP_TOP_DEFINES_SVH
`define FNV1A_BLOOM_FILTER_MEMBERSHIP_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked on every clock edge outside of reset.
`define FBM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define FBM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define FBM_ASSERT(label, prop, msg)
`define FBM_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[rtl/fbm_pkg.sv]
// Package for the FNV-1a Bloom filter block: hash constants, filter geometry,
// mode codes and the filter request struct. No dependencies.
`default_nettype none

package fbm_pkg;

    localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
    localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

    localparam int BLOOM_WORD_COUNT = 4;
    localparam int BLOOM_WORD_WIDTH = 64;

    typedef enum logic {
        MODE_LOOKUP = 1'b0,
        MODE_INTERN = 1'b1
    } t_mode;

    // One filter transaction: test the three positions taken from hash bits
    // 7:0, 15:8 and 23:16, and set them afterwards when upd and set are both high.
    typedef struct packed {
        logic        upd;
        logic        set;
        logic [23:0] hash;
    } t_bloom_req;

endpackage

`default_nettype wire

[rtl/fbm_if.sv]
// Valid/ready stream interfaces for the FNV-1a Bloom filter block:
// one for string bytes in, one for hash results out. No dependencies.
`default_nettype none

interface fbm_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;

    modport source (output valid, mode, data_byte, has_byte, last_byte, input ready);
    modport sink   (input valid, mode, data_byte, has_byte, last_byte, output ready);
endinterface

interface fbm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;
    logic        maybe_present;

    modport source (output valid, hash_value, maybe_present, input ready);
    modport sink   (input valid, hash_value, maybe_present, output ready);
endinterface

`default_nettype wire

[rtl/fbm_bloom.sv]
// 256-bit Bloom filter held in four 64-bit words: three-position test and set.
// Depends on fbm_pkg and the assertion macro header.
`default_nettype none
`include "fnv1a_bloom_filter_membership_top_defines.svh"

module fbm_bloom import fbm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_bloom_req i_req,
    output logic       o_hit
);

    logic [BLOOM_WORD_COUNT-1:0][BLOOM_WORD_WIDTH-1:0] r_words;
    logic [BLOOM_WORD_COUNT-1:0][BLOOM_WORD_WIDTH-1:0] n_words;
    logic [BLOOM_WORD_COUNT*BLOOM_WORD_WIDTH-1:0]      w_flat;
    logic [7:0] w_p0;
    logic [7:0] w_p1;
    logic [7:0] w_p2;
    logic       w_set;

    assign w_p0  = i_req.hash[7:0];
    assign w_p1  = i_req.hash[15:8];
    assign w_p2  = i_req.hash[23:16];
    assign w_set = i_req.upd && i_req.set;

    // Position b lives in bit b[5:0] of word b[7:6], which is bit b of the flat view.
    assign w_flat = r_words;
    assign o_hit  = w_flat[w_p0] && w_flat[w_p1] && w_flat[w_p2];

    always_comb begin
        n_words = r_words;
        if (w_set) begin
            n_words[w_p0[7:6]][w_p0[5:0]] = 1'b1;
            n_words[w_p1[7:6]][w_p1[5:0]] = 1'b1;
            n_words[w_p2[7:6]][w_p2[5:0]] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words <= '0;
        end else begin
            r_words <= n_words;
        end
    end

    `FBM_ASSERT(a_set_p0, w_set |=> w_flat[$past(w_p0)], "filter bit 0 not set after intern")
    `FBM_ASSERT(a_set_p2, w_set |=> w_flat[$past(w_p2)], "filter bit 2 not set after intern")
    `FBM_ASSERT(a_sticky, $past(i_rst_n) |-> (~w_flat & $past(w_flat)) == '0, "filter bit cleared")

endmodule

`default_nettype wire

[rtl/fnv1a_bloom_filter_membership_top.sv]
// A result is registered in the output stage when its last-byte transaction leaves the input stage.
// Throughput: one byte transaction per cycle, sustained; bytes keep flowing while a
// finished result waits in the output register.
// A last-byte transaction stalls the input only while the previous result is not yet taken.
// Reset (synchronous, active low) empties both stages, loads the FNV offset basis into the
// running hash and clears all 256 filter bits.
`default_nettype none
`include "fnv1a_bloom_filter_membership_top_defines.svh"

module fnv1a_bloom_filter_membership_top import fbm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fbm_in_if.sink    i_in,
    fbm_out_if.source o_out
);

    // The block has two register stages:
    //   input stage  - holds one accepted byte transaction as it arrived;
    //   output stage - holds the finished hash and the filter verdict for the sink.
    // Between them sit the XOR, the constant multiply by the FNV prime and the
    // filter test and update, all in one pass. The running hash advances when an
    // item leaves the input stage. A last-byte item leaves only when the output
    // stage can take its result, so the filter is read and written in
    // transaction order.

    // Input stage.
    logic       r_in_valid;
    logic       r_in_mode;
    logic [7:0] r_in_byte;
    logic       r_in_has;
    logic       r_in_last;

    // Running hash.
    logic [31:0] r_run;
    logic [31:0] n_run;
    logic [31:0] w_mixed;

    // Output stage.
    logic        r_out_valid;
    logic [31:0] r_out_hash;
    logic        r_out_hit;

    // Stage control. A byte that does not end a string never needs the output
    // stage; a last byte needs it empty or draining.
    logic w_en_out;
    logic w_en_in;
    logic w_adv_in;
    logic w_fin;

    t_bloom_req w_req;
    logic       w_hit;

    assign w_en_out = !r_out_valid || o_out.ready;
    assign w_adv_in = r_in_valid && (!r_in_last || w_en_out);
    assign w_en_in  = !r_in_valid || w_adv_in;
    assign w_fin    = w_adv_in && r_in_last;

    assign i_in.ready = w_en_in;

    // Input stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_en_in) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_in && i_in.valid) begin
            r_in_mode <= i_in.mode;
            r_in_byte <= i_in.data_byte;
            r_in_has  <= i_in.has_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    // FNV-1a step: XOR the byte into the low bits, then multiply by the prime
    // modulo 2^32. A transaction without a byte leaves the hash unchanged.
    assign w_mixed = r_run ^ {24'h00_0000, r_in_byte};
    assign n_run   = r_in_has ? 32'(w_mixed * FNV_PRIME) : r_run;

    // The running hash restarts from the offset basis once a string finishes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= FNV_BASIS;
        end else if (w_adv_in) begin
            r_run <= r_in_last ? FNV_BASIS : n_run;
        end
    end

    // Filter: the test sees the bits as they stood before this string's
    // own insert, which lands at the same edge the result is registered.
    // Only the mode of the last transaction of a string counts.
    assign w_req.upd  = w_fin;
    assign w_req.set  = (r_in_mode == MODE_INTERN);
    assign w_req.hash = n_run[23:0];

    fbm_bloom u_bloom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_hit   (w_hit)
    );

    // Output stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en_out) begin
            r_out_valid <= w_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_out_hash <= n_run;
            r_out_hit  <= w_hit;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.hash_value    = r_out_hash;
    assign o_out.maybe_present = r_out_hit;

    `FBM_ASSERT_ALWAYS(a_rst_basis, $past(!i_rst_n) |-> (r_run == FNV_BASIS), "hash not reset")
    `FBM_ASSERT(a_last_basis, w_fin |=> (r_run == FNV_BASIS), "hash not restarted")
    `FBM_ASSERT(a_full_stall, !i_in.ready |-> (r_out_valid && !o_out.ready), "input stalled")
    `FBM_ASSERT(a_out_source, $rose(r_out_valid) |-> $past(w_fin), "result without a last byte")

endmodule

`default_nettype wire
